[hdl/ps2kc_pkg.sv]
// ----------------------------------------------------------------------------
// ps2kc_pkg
// Shared types and byte codes of the PS/2 keyboard controller core: bus
// operation codes, controller and keyboard command bytes, response bytes.
// ----------------------------------------------------------------------------
package ps2kc_pkg;

   // Bus operation codes carried by the request channel.
   localparam logic [1:0] OP_BUS_READ  = 2'd0;
   localparam logic [1:0] OP_BUS_WRITE = 2'd1;
   localparam logic [1:0] OP_INJECT    = 2'd2;

   // Port select values.
   localparam logic PORT_DATA   = 1'b0;
   localparam logic PORT_CMD    = 1'b1;

   // Controller commands written to the command port.
   localparam logic [7:0] CC_SELF_TEST    = 8'hAA;
   localparam logic [7:0] CC_KBD_IF_TEST  = 8'hAB;
   localparam logic [7:0] CC_AUX_IF_TEST  = 8'hA9;
   localparam logic [7:0] CC_READ_CMD     = 8'h20;
   localparam logic [7:0] CC_KBD_DISABLE  = 8'hAD;
   localparam logic [7:0] CC_KBD_ENABLE   = 8'hAE;
   localparam logic [7:0] CC_WRITE_CMD    = 8'h60;
   localparam logic [7:0] CC_WRITE_OUTP   = 8'hD1;
   localparam logic [7:0] CC_WRITE_AUX    = 8'hD4;

   // Keyboard commands written to the data port.
   localparam logic [7:0] KB_RESET        = 8'hFF;
   localparam logic [7:0] KB_IDENTIFY     = 8'hF2;
   localparam logic [7:0] KB_SCAN_OFF     = 8'hF5;
   localparam logic [7:0] KB_SCAN_ON      = 8'hF4;
   localparam logic [7:0] KB_SCAN_SET     = 8'hF0;
   localparam logic [7:0] KB_SET_LEDS     = 8'hED;
   localparam logic [7:0] KB_TYPEMATIC    = 8'hF3;

   // Bytes queued in the output buffer.
   localparam logic [7:0] RSP_TEST_OK     = 8'h55;
   localparam logic [7:0] RSP_ZERO        = 8'h00;
   localparam logic [7:0] RSP_CMD_BYTE    = 8'h47;
   localparam logic [7:0] RSP_ACK         = 8'hFA;
   localparam logic [7:0] RSP_BAT_OK      = 8'hAA;
   localparam logic [7:0] RSP_ID_FIRST    = 8'hAB;
   localparam logic [7:0] RSP_ID_SECOND   = 8'h83;

   // Status register bits.
   localparam logic [7:0] STATUS_BASE     = 8'h04;
   localparam logic [7:0] STATUS_OBF      = 8'h01;

   // Controller command waiting for its data byte.
   typedef enum logic [1:0] {
      ARM_NONE     = 2'd0,
      ARM_CMD_BYTE = 2'd1,
      ARM_OUT_PORT = 2'd2,
      ARM_AUX      = 2'd3
   } arm_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_READ,
      ST_DONE
   } state_type;

endpackage

[hdl/ps2kc_if.sv]
// ----------------------------------------------------------------------------
// ps2kc_req_if / ps2kc_rsp_if
// Valid/ready channels of the PS/2 keyboard controller core: bus requests in,
// one response per request out.
// ----------------------------------------------------------------------------
interface ps2kc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic       port_select;
   logic [7:0] data_byte;

   modport source (output valid, output operation, output port_select,
                   output data_byte, input ready);
   modport sink   (input valid, input operation, input port_select,
                   input data_byte, output ready);
endinterface

interface ps2kc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       output_full;
   logic [6:0] fifo_level;
   logic       scanning_enabled;

   modport source (output valid, output read_data, output output_full,
                   output fifo_level, output scanning_enabled, input ready);
   modport sink   (input valid, input read_data, input output_full,
                   input fifo_level, input scanning_enabled, output ready);
endinterface

[hdl/ps2kc_ram.sv]
// ----------------------------------------------------------------------------
// ps2kc_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module ps2kc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hdl/ps2_keyboard_controller_core.sv]
// ----------------------------------------------------------------------------
// ps2_keyboard_controller_core
// Simplified 8042 keyboard controller with a byte output buffer in RAM.
//
// Usage: every transfer on req_chan is a bus read or write of the data port
// or the command/status port, or an injected scancode. Each request yields
// exactly one transfer on rsp_chan with the read byte (zero for writes and
// injections), the buffer level, the output-full flag and the scan-enable
// flag as they stand after the request.
// Sequence: a status read, a write that queues nothing or an empty data read
// goes from ST_IDLE to ST_DONE, which loads the response register; a data
// read that pops a byte passes through ST_READ for the registered RAM read;
// a request that queues N bytes (1 to 3) passes through ST_PUSH once per
// byte, since the buffer RAM takes one write per cycle. A new request is
// taken only once the previous one has its response registered.
// Reset: scanning on, buffer empty, nothing armed; the buffer RAM itself is
// not cleared, and no clearing pass is needed.
// Stall: a response waiting in the output register does not block the next
// request; the sequencer holds in its final state only if the output
// register is still full when the next response is ready.
// ----------------------------------------------------------------------------
module ps2_keyboard_controller_core #(
   parameter int FIFO_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   ps2kc_req_if.sink    req_chan,
   ps2kc_rsp_if.source  rsp_chan
);

   import ps2kc_pkg::*;

   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

   // Control state.
   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   arm_type            armed_ff, armed_in;
   logic               param_ff, param_in;
   logic               scan_ff, scan_in;
   logic [1:0]         left_ff, left_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload state.
   logic [7:0]         push_bytes_ff [3];
   logic [7:0]         push_bytes_in [3];
   logic [7:0]         rdata_ff, rdata_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   logic               rsp_full_ff, rsp_full_in;
   logic [6:0]         rsp_level_ff, rsp_level_in;
   logic               rsp_scan_ff, rsp_scan_in;

   // Buffer RAM ports.
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [7:0]         ram_rd_data;

   logic               rsp_free;
   logic [FILL_W+6:0]  level_ext;

   ps2kc_ram #(
      .WIDTH (8),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (push_bytes_ff[0]),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign rsp_free                  = !rsp_valid_ff || rsp_chan.ready;
   assign level_ext                 = {7'd0, fill_ff};

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.read_data        = rsp_data_ff;
   assign rsp_chan.output_full      = rsp_full_ff;
   assign rsp_chan.fifo_level       = rsp_level_ff;
   assign rsp_chan.scanning_enabled = rsp_scan_ff;

   // Sequencer: decode a request, push its bytes one per cycle or read the
   // buffer RAM, then load the response register.
   always_comb begin
      state_in         = state_ff;
      wr_ptr_in        = wr_ptr_ff;
      rd_ptr_in        = rd_ptr_ff;
      fill_in          = fill_ff;
      armed_in         = armed_ff;
      param_in         = param_ff;
      scan_in          = scan_ff;
      left_in          = left_ff;
      rsp_valid_in     = rsp_valid_ff;
      push_bytes_in[0] = push_bytes_ff[0];
      push_bytes_in[1] = push_bytes_ff[1];
      push_bytes_in[2] = push_bytes_ff[2];
      rdata_in         = rdata_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_full_in      = rsp_full_ff;
      rsp_level_in     = rsp_level_ff;
      rsp_scan_in      = rsp_scan_ff;
      ram_wr_en        = 1'b0;
      ram_rd_en        = 1'b0;

      // The response register empties on its transfer.
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               rdata_in = RSP_ZERO;
               left_in  = 2'd0;
               state_in = ST_DONE;
               unique case (req_chan.operation)
                  OP_BUS_READ: begin
                     if (req_chan.port_select == PORT_CMD) begin
                        rdata_in = STATUS_BASE |
                                   ((fill_ff != '0) ? STATUS_OBF : RSP_ZERO);
                     end else if (fill_ff != '0) begin
                        // Pop: the byte arrives from the RAM next cycle.
                        ram_rd_en = 1'b1;
                        rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ?
                                    '0 : rd_ptr_ff + 1'b1;
                        fill_in   = fill_ff - 1'b1;
                        state_in  = ST_READ;
                     end
                  end
                  OP_BUS_WRITE: begin
                     if (req_chan.port_select == PORT_CMD) begin
                        // Controller command.
                        unique case (req_chan.data_byte)
                           CC_SELF_TEST: begin
                              push_bytes_in[0] = RSP_TEST_OK;
                              left_in          = 2'd1;
                           end
                           CC_KBD_IF_TEST, CC_AUX_IF_TEST: begin
                              push_bytes_in[0] = RSP_ZERO;
                              left_in          = 2'd1;
                           end
                           CC_READ_CMD: begin
                              push_bytes_in[0] = RSP_CMD_BYTE;
                              left_in          = 2'd1;
                           end
                           CC_KBD_DISABLE: scan_in  = 1'b0;
                           CC_KBD_ENABLE:  scan_in  = 1'b1;
                           CC_WRITE_CMD:   armed_in = ARM_CMD_BYTE;
                           CC_WRITE_OUTP:  armed_in = ARM_OUT_PORT;
                           CC_WRITE_AUX:   armed_in = ARM_AUX;
                           default: ;
                        endcase
                     end else if (armed_ff != ARM_NONE) begin
                        // Data byte of an armed controller command.
                        if (armed_ff == ARM_AUX) begin
                           push_bytes_in[0] = RSP_ACK;
                           left_in          = 2'd1;
                        end
                        armed_in = ARM_NONE;
                     end else begin
                        // Keyboard command: always acknowledged.
                        push_bytes_in[0] = RSP_ACK;
                        left_in          = 2'd1;
                        unique case (req_chan.data_byte)
                           KB_RESET: begin
                              push_bytes_in[1] = RSP_BAT_OK;
                              left_in          = 2'd2;
                           end
                           KB_IDENTIFY: begin
                              push_bytes_in[1] = RSP_ID_FIRST;
                              push_bytes_in[2] = RSP_ID_SECOND;
                              left_in          = 2'd3;
                           end
                           KB_SCAN_OFF: scan_in = 1'b0;
                           KB_SCAN_ON:  scan_in = 1'b1;
                           KB_SCAN_SET, KB_SET_LEDS, KB_TYPEMATIC: param_in = 1'b1;
                           default: param_in = 1'b0;
                        endcase
                     end
                  end
                  OP_INJECT: begin
                     if (scan_ff) begin
                        push_bytes_in[0] = req_chan.data_byte;
                        left_in          = 2'd1;
                     end
                  end
                  default: ;
               endcase
               if (left_in != 2'd0) begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            // One byte per cycle; a byte for a full buffer is dropped.
            if (fill_ff != FILL_W'(FIFO_DEPTH)) begin
               ram_wr_en = 1'b1;
               wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ?
                           '0 : wr_ptr_ff + 1'b1;
               fill_in   = fill_ff + 1'b1;
            end
            push_bytes_in[0] = push_bytes_ff[1];
            push_bytes_in[1] = push_bytes_ff[2];
            left_in          = left_ff - 1'b1;
            if (left_ff == 2'd1) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            rdata_in = ram_rd_data;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rdata_ff;
               rsp_full_in  = (fill_ff != '0);
               rsp_level_in = level_ext[6:0];
               rsp_scan_in  = scan_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         armed_ff     <= ARM_NONE;
         param_ff     <= 1'b0;
         scan_ff      <= 1'b1;
         left_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         armed_ff     <= armed_in;
         param_ff     <= param_in;
         scan_ff      <= scan_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      push_bytes_ff[0] <= push_bytes_in[0];
      push_bytes_ff[1] <= push_bytes_in[1];
      push_bytes_ff[2] <= push_bytes_in[2];
      rdata_ff         <= rdata_in;
      rsp_data_ff      <= rsp_data_in;
      rsp_full_ff      <= rsp_full_in;
      rsp_level_ff     <= rsp_level_in;
      rsp_scan_ff      <= rsp_scan_in;
   end

endmodule
